// ===== rtl/core/clcd_pkg.sv =====
// shared types and constants for the character lcd write sequencer
package clcd_pkg;

  // input action codes (carried on in_tuser)
  typedef enum logic [2:0] {
    ACT_TICK    = 3'd0,
    ACT_INIT    = 3'd1,
    ACT_RAW_CMD = 3'd2,
    ACT_RAW_DAT = 3'd3,
    ACT_SET_ADR = 3'd4,
    ACT_GLYPH   = 3'd5,
    ACT_CLEAR   = 3'd6,
    ACT_CHAR    = 3'd7
  } action_t;

  // configuration register indexes
  localparam logic [2:0] REG_POWER_UP = 3'd0;
  localparam logic [2:0] REG_CMD_WAIT = 3'd1;
  localparam logic [2:0] REG_DAT_WAIT = 3'd2;
  localparam logic [2:0] REG_CLR_WAIT = 3'd3;
  localparam logic [2:0] REG_STROBE   = 3'd4;

  localparam logic [11:0] POWER_UP_RESET = 12'd3000;
  localparam logic [7:0]  CMD_WAIT_RESET = 8'd4;
  localparam logic [7:0]  DAT_WAIT_RESET = 8'd5;
  localparam logic [7:0]  CLR_WAIT_RESET = 8'd153;
  localparam logic [3:0]  STROBE_RESET   = 4'd1;

  localparam logic [7:0] CMD_FUNC_SET  = 8'h38;
  localparam logic [7:0] CMD_DISP_ON   = 8'h0C;
  localparam logic [7:0] CMD_CLEAR     = 8'h01;
  localparam logic [7:0] CMD_ENTRY     = 8'h06;
  localparam logic [7:0] CMD_SET_CGRAM = 8'b0100_0000;
  localparam logic [7:0] CMD_SET_DDRAM = 8'b1000_0000;

  // init command index of the clear command
  localparam logic [1:0] INIT_CLEAR_IDX = 2'd2;

  typedef struct packed {
    logic [11:0] power_up_ticks;
    logic [7:0]  command_wait_ticks;
    logic [7:0]  data_wait_ticks;
    logic [7:0]  clear_wait_ticks;
    logic [3:0]  strobe_ticks;
  } cfg_t;

  typedef struct packed {
    logic [7:0] data_pins;
    logic       register_select;
    logic       enable_pin;
    logic       busy_res;
    logic       accepted;
  } result_t;

  function automatic logic [7:0] init_byte(input logic [1:0] idx);
    logic [7:0] b;
    case (idx)
      2'd0:    b = CMD_FUNC_SET;
      2'd1:    b = CMD_DISP_ON;
      2'd2:    b = CMD_CLEAR;
      default: b = CMD_ENTRY;
    endcase
    return b;
  endfunction

endpackage

// ===== rtl/core/char_lcd_write_sequencer_core.sv =====
// top level of the character lcd write sequencer: config registers and result register
// a result is registered and valid in the cycle after its input transaction is accepted
// throughput: one input transaction per cycle; in_tready drops only while a
//   result sits in the output register and out_tready is low
// reset (synchronous, rst_n low): sequencer idle, pins and counters zero,
//   timing registers back to their defaults, output register empty
module char_lcd_write_sequencer_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // byte_value[7:0], target_address[14:8], raw_wait[22:15]
  input  logic [2:0]  in_tuser,   // action[2:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // data_pins[7:0], enable_pin[8], busy_res[9], accepted[10]
  output logic        out_tuser,  // register_select[0]
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [11:0] cfg_data
);

  clcd_pkg::cfg_t      cfg_r;
  clcd_pkg::result_t   res;
  clcd_pkg::result_t   res_r;
  clcd_pkg::action_t   action;
  logic                out_valid_r;
  logic                take;

  assign cfg_ready = 1'b1;
  assign in_tready = !out_valid_r || out_tready;
  assign take      = in_tvalid && in_tready;
  assign action    = clcd_pkg::action_t'(in_tuser);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.power_up_ticks     <= clcd_pkg::POWER_UP_RESET;
      cfg_r.command_wait_ticks <= clcd_pkg::CMD_WAIT_RESET;
      cfg_r.data_wait_ticks    <= clcd_pkg::DAT_WAIT_RESET;
      cfg_r.clear_wait_ticks   <= clcd_pkg::CLR_WAIT_RESET;
      cfg_r.strobe_ticks       <= clcd_pkg::STROBE_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        clcd_pkg::REG_POWER_UP: cfg_r.power_up_ticks     <= cfg_data;
        clcd_pkg::REG_CMD_WAIT: cfg_r.command_wait_ticks <= cfg_data[7:0];
        clcd_pkg::REG_DAT_WAIT: cfg_r.data_wait_ticks    <= cfg_data[7:0];
        clcd_pkg::REG_CLR_WAIT: cfg_r.clear_wait_ticks   <= cfg_data[7:0];
        clcd_pkg::REG_STROBE:   cfg_r.strobe_ticks       <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  clcd_seq u_seq (
    .clk            (clk),
    .rst_n          (rst_n),
    .take           (take),
    .action         (action),
    .byte_value     (in_tdata[7:0]),
    .target_address (in_tdata[14:8]),
    .raw_wait       (in_tdata[22:15]),
    .cfg            (cfg_r),
    .result         (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (take) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {5'd0, res_r.accepted, res_r.busy_res, res_r.enable_pin,
                       res_r.data_pins};
  assign out_tuser  = res_r.register_select;

`ifndef SYNTH
  // the strobe is only ever high inside a busy write
  a_strobe_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[8] |-> out_tdata[9])
    else $error("enable high while not busy");

  // a tick never counts as a taken request
  a_tick_not_acc: assert property (@(posedge clk) disable iff (!rst_n)
    take && (in_tuser == clcd_pkg::ACT_TICK) |=> !out_tdata[10])
    else $error("tick reported as accepted");

  // a taken request always leaves the sequencer busy
  a_acc_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[10] |-> out_tdata[9])
    else $error("accepted request left sequencer idle");
`endif

endmodule

// ===== rtl/core/clcd_seq.sv =====
// write sequencer state machine: phase, tick counter, init step and pin state
module clcd_seq (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                take,
  input  clcd_pkg::action_t   action,
  input  logic [7:0]          byte_value,
  input  logic [6:0]          target_address,
  input  logic [7:0]          raw_wait,
  input  clcd_pkg::cfg_t      cfg,
  output clcd_pkg::result_t   result
);

  typedef enum logic [1:0] {
    PH_IDLE   = 2'd0,
    PH_POWER  = 2'd1,
    PH_STROBE = 2'd2,
    PH_HOLD   = 2'd3
  } phase_t;

  phase_t      phase_r, phase_nxt;
  logic [11:0] cnt_r, cnt_nxt;
  logic [2:0]  step_r, step_nxt;
  logic [7:0]  held_r, held_nxt;
  logic        sel_r, sel_nxt;
  logic [7:0]  pend_r, pend_nxt;

  logic        acc;
  logic        wr;
  logic        init_wr;
  logic [1:0]  init_idx;
  logic        fin;
  logic [7:0]  wr_byte;
  logic        wr_rs;
  logic [7:0]  wr_wait;
  logic [11:0] cnt_dec;
  logic [3:0]  strobe_len;

  assign strobe_len = (cfg.strobe_ticks == 4'd0) ? 4'd1 : cfg.strobe_ticks;
  assign cnt_dec    = (cnt_r != 12'd0) ? cnt_r - 12'd1 : 12'd0;

  always_comb begin
    phase_nxt = phase_r;
    cnt_nxt   = cnt_r;
    step_nxt  = step_r;
    held_nxt  = held_r;
    sel_nxt   = sel_r;
    pend_nxt  = pend_r;
    acc       = 1'b0;
    wr        = 1'b0;
    init_wr   = 1'b0;
    init_idx  = 2'd0;
    fin       = 1'b0;
    wr_byte   = 8'd0;
    wr_rs     = 1'b0;
    wr_wait   = 8'd0;

    if (action == clcd_pkg::ACT_TICK) begin
      if (phase_r != PH_IDLE) begin
        if (cnt_dec != 12'd0) begin
          cnt_nxt = cnt_dec;
        end else begin
          case (phase_r)
            PH_POWER: begin
              step_nxt = 3'd1;
              init_wr  = 1'b1;
              init_idx = 2'd0;
            end
            PH_STROBE: begin
              phase_nxt = PH_HOLD;
              cnt_nxt   = {4'd0, pend_r};
              fin       = (pend_r == 8'd0);
            end
            default: fin = 1'b1;
          endcase
        end
      end
      // end of a write: next init command or back to idle
      if (fin) begin
        if (step_r inside {3'd1, 3'd2, 3'd3}) begin
          step_nxt = step_r + 3'd1;
          init_wr  = 1'b1;
          init_idx = step_r[1:0];
        end else begin
          step_nxt  = 3'd0;
          phase_nxt = PH_IDLE;
          cnt_nxt   = 12'd0;
        end
      end
    end else if (phase_r == PH_IDLE) begin
      acc = 1'b1;
      case (action)
        clcd_pkg::ACT_INIT: begin
          if (cfg.power_up_ticks == 12'd0) begin
            step_nxt = 3'd1;
            init_wr  = 1'b1;
            init_idx = 2'd0;
          end else begin
            step_nxt  = 3'd0;
            phase_nxt = PH_POWER;
            cnt_nxt   = cfg.power_up_ticks;
          end
        end
        clcd_pkg::ACT_RAW_CMD: begin
          wr = 1'b1; wr_byte = byte_value; wr_rs = 1'b0; wr_wait = raw_wait;
        end
        clcd_pkg::ACT_RAW_DAT: begin
          wr = 1'b1; wr_byte = byte_value; wr_rs = 1'b1; wr_wait = raw_wait;
        end
        clcd_pkg::ACT_SET_ADR: begin
          wr      = 1'b1;
          wr_byte = clcd_pkg::CMD_SET_DDRAM | {1'b0, target_address};
          wr_wait = cfg.command_wait_ticks;
        end
        clcd_pkg::ACT_GLYPH: begin
          wr      = 1'b1;
          wr_byte = clcd_pkg::CMD_SET_CGRAM | {2'b00, target_address[2:0], 3'b000};
          wr_wait = cfg.command_wait_ticks;
        end
        clcd_pkg::ACT_CLEAR: begin
          wr      = 1'b1;
          wr_byte = clcd_pkg::CMD_CLEAR;
          wr_wait = cfg.clear_wait_ticks;
        end
        default: begin
          wr = 1'b1; wr_byte = byte_value; wr_rs = 1'b1; wr_wait = cfg.data_wait_ticks;
        end
      endcase
    end

    if (init_wr) begin
      wr      = 1'b1;
      wr_byte = clcd_pkg::init_byte(init_idx);
      wr_rs   = 1'b0;
      wr_wait = (init_idx == clcd_pkg::INIT_CLEAR_IDX) ? cfg.clear_wait_ticks
                                                        : cfg.command_wait_ticks;
    end

    if (wr) begin
      held_nxt  = wr_byte;
      sel_nxt   = wr_rs;
      pend_nxt  = wr_wait;
      cnt_nxt   = {8'd0, strobe_len};
      phase_nxt = PH_STROBE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      cnt_r   <= 12'd0;
      step_r  <= 3'd0;
      held_r  <= 8'd0;
      sel_r   <= 1'b0;
      pend_r  <= 8'd0;
    end else if (take) begin
      phase_r <= phase_nxt;
      cnt_r   <= cnt_nxt;
      step_r  <= step_nxt;
      held_r  <= held_nxt;
      sel_r   <= sel_nxt;
      pend_r  <= pend_nxt;
    end
  end

  assign result.data_pins       = held_nxt;
  assign result.register_select = sel_nxt;
  assign result.enable_pin      = (phase_nxt == PH_STROBE);
  assign result.busy_res        = (phase_nxt != PH_IDLE);
  assign result.accepted        = acc;

endmodule
